// ===== sv/gfbs_pkg.sv =====
package gfbs_pkg;

  localparam int unsigned StackDepthDef = 32;
  localparam int unsigned BlockW        = 24;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_FILL  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ORDER   = 2'd2
  } status_e;

endpackage

// ===== sv/gfbs_ram.sv =====
module gfbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/grouped_free_block_stack.sv =====
// pops and frees on an empty stack (end mark planted first) go via S_POP or S_PLANT;
// other frees, fill words and refused requests load results directly, one per cycle
// unless stalled; a full-stack free spills 1 + STACK_DEPTH words, one per cycle when not
// stalled, set by the single stack read port; next request taken after the last word
// reset clears count, fill state and dirty flag; stack memory contents stay undefined
// and need no clearing pass, since no entry is read before it is written
module grouped_free_block_stack
  import gfbs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [BlockW-1:0] block_number_i,
  // result side
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [BlockW-1:0] granted_block_o,
  output logic              fetch_request_o,
  output logic              spill_valid_o,
  output logic [BlockW-1:0] spill_target_o,
  output logic [BlockW-1:0] spill_word_o,
  output logic              dirty_o,
  output logic              last_o
);

  // count holds 0..STACK_DEPTH, address picks one of STACK_DEPTH entries
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam logic [CntW-1:0] DepthCnt = CntW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_PLANT,
    S_SPILL
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              filling_q, filling_d;
  logic [CntW-1:0]   fill_pos_q, fill_pos_d;
  logic              modified_q, modified_d;
  // spill walk: word index, and whether the count word has gone out
  logic [CntW-1:0]   spill_idx_q, spill_idx_d;
  logic              spill_cnt_done_q, spill_cnt_done_d;
  // block being freed, kept for the plant and spill steps
  logic [BlockW-1:0] held_blk_q, held_blk_d;

  // result register
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [BlockW-1:0] granted_q, granted_d;
  logic              fetch_q, fetch_d;
  logic              spill_valid_q, spill_valid_d;
  logic [BlockW-1:0] spill_target_q, spill_target_d;
  logic [BlockW-1:0] spill_word_q, spill_word_d;
  logic              dirty_q, dirty_d;
  logic              last_q, last_d;

  // stack memory port signals
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [BlockW-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [BlockW-1:0] mem_rdata;

  logic out_free;
  logic in_accept;
  logic out_load;

  gfbs_ram #(
    .Width (BlockW),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result register can take a new word when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    filling_d        = filling_q;
    fill_pos_d       = fill_pos_q;
    modified_d       = modified_q;
    spill_idx_d      = spill_idx_q;
    spill_cnt_done_d = spill_cnt_done_q;
    held_blk_d       = held_blk_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    // default result word: ok, data fields zero, last set to close the request
    out_load       = 1'b0;
    status_d       = ST_OK;
    granted_d      = '0;
    fetch_d        = 1'b0;
    spill_valid_d  = 1'b0;
    spill_target_d = '0;
    spill_word_d   = '0;
    last_d         = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          out_load = 1'b1;
          case (action_i)
            ACT_FILL: begin
              if (!filling_q) begin
                status_d = ST_ORDER;
              end else begin
                if (fill_pos_q == '0) begin
                  // count word, saturated to the stack depth
                  if (block_number_i > BlockW'(STACK_DEPTH)) begin
                    count_d = DepthCnt;
                  end else begin
                    count_d = block_number_i[CntW-1:0];
                  end
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = AddrW'(fill_pos_q - 1'b1);
                  mem_wdata = block_number_i;
                end
                if (fill_pos_q == DepthCnt) begin
                  filling_d  = 1'b0;
                  fill_pos_d = '0;
                end else begin
                  fill_pos_d = fill_pos_q + 1'b1;
                end
              end
            end
            ACT_ALLOC: begin
              if (filling_q) begin
                status_d = ST_ORDER;
              end else if (count_q == '0) begin
                status_d = ST_NOSPACE;
              end else begin
                // pop: read top entry, decide in S_POP
                out_load  = 1'b0;
                count_d   = count_q - 1'b1;
                mem_re    = 1'b1;
                mem_raddr = AddrW'(count_q - 1'b1);
                state_d   = S_POP;
              end
            end
            ACT_FREE: begin
              if (filling_q) begin
                status_d = ST_ORDER;
              end else begin
                modified_d = 1'b1;
                held_blk_d = block_number_i;
                if (count_q == '0) begin
                  // plant end-of-chain mark, push the block in S_PLANT
                  out_load  = 1'b0;
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = '0;
                  count_d   = CntW'(1);
                  state_d   = S_PLANT;
                end else if (count_q == DepthCnt) begin
                  out_load         = 1'b0;
                  spill_idx_d      = '0;
                  spill_cnt_done_d = 1'b0;
                  state_d          = S_SPILL;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = AddrW'(count_q);
                  mem_wdata = block_number_i;
                  count_d   = count_q + 1'b1;
                end
              end
            end
            default: begin
              status_d = ST_ORDER;
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (mem_rdata == '0) begin
            // end-of-chain mark: no space left
            status_d = ST_NOSPACE;
            count_d  = '0;
          end else begin
            modified_d = 1'b1;
            granted_d  = mem_rdata;
            if (count_q == '0) begin
              // stack emptied: host fetches the next group from this block
              fetch_d    = 1'b1;
              filling_d  = 1'b1;
              fill_pos_d = '0;
            end
          end
        end
      end

      S_PLANT: begin
        if (out_free) begin
          out_load  = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = AddrW'(count_q);
          mem_wdata = held_blk_q;
          count_d   = count_q + 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_SPILL: begin
        if (out_free) begin
          out_load       = 1'b1;
          spill_valid_d  = 1'b1;
          spill_target_d = held_blk_q;
          if (!spill_cnt_done_q) begin
            // count word first, start reading entry 0
            spill_word_d     = BlockW'(count_q);
            last_d           = 1'b0;
            spill_cnt_done_d = 1'b1;
            mem_re           = 1'b1;
            mem_raddr        = '0;
          end else begin
            spill_word_d = mem_rdata;
            if (spill_idx_q == DepthCnt - 1'b1) begin
              // stack now holds only the freed block
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = held_blk_q;
              count_d   = CntW'(1);
              state_d   = S_IDLE;
            end else begin
              last_d      = 1'b0;
              spill_idx_d = spill_idx_q + 1'b1;
              mem_re      = 1'b1;
              mem_raddr   = AddrW'(spill_idx_q + 1'b1);
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    dirty_d = modified_d;

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      count_q          <= '0;
      filling_q        <= 1'b0;
      fill_pos_q       <= '0;
      modified_q       <= 1'b0;
      spill_idx_q      <= '0;
      spill_cnt_done_q <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      count_q          <= count_d;
      filling_q        <= filling_d;
      fill_pos_q       <= fill_pos_d;
      modified_q       <= modified_d;
      spill_idx_q      <= spill_idx_d;
      spill_cnt_done_q <= spill_cnt_done_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    held_blk_q <= held_blk_d;
    if (out_load) begin
      status_q       <= status_d;
      granted_q      <= granted_d;
      fetch_q        <= fetch_d;
      spill_valid_q  <= spill_valid_d;
      spill_target_q <= spill_target_d;
      spill_word_q   <= spill_word_d;
      dirty_q        <= dirty_d;
      last_q         <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = granted_q;
  assign fetch_request_o = fetch_q;
  assign spill_valid_o   = spill_valid_q;
  assign spill_target_o  = spill_target_q;
  assign spill_word_o    = spill_word_q;
  assign dirty_o         = dirty_q;
  assign last_o          = last_q;

endmodule

// ===== tb/sv/grouped_free_block_stack_checker.sv =====
`timescale 1ns / 100ps

module grouped_free_block_stack_checker
  import gfbs_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [BlockW-1:0] block_number_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [1:0]        status_o,
  input  logic [BlockW-1:0] granted_block_o,
  input  logic              fetch_request_o,
  input  logic              spill_valid_o,
  input  logic [BlockW-1:0] spill_target_o,
  input  logic [BlockW-1:0] spill_word_o,
  input  logic              dirty_o,
  input  logic              last_o,
  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o,
  output logic              group_due_o,
  output int unsigned       level_o,
  output int unsigned       results_o,
  output int unsigned       spill_runs_o,
  output int unsigned       fetches_o,
  output int unsigned       no_space_o,
  output int unsigned       refused_o
);

  typedef struct {
    status_e           status;
    logic [BlockW-1:0] granted;
    logic              fetch;
    logic              spill;
    logic [BlockW-1:0] target;
    logic [BlockW-1:0] word;
    logic              dirty;
    logic              last;
  } outcome_t;

  // shadow of the free list
  logic [BlockW-1:0] stack_mem [STACK_DEPTH];
  int unsigned       level;
  bit                group_fill;
  int unsigned       fill_pos;
  bit                changed;

  outcome_t    outcome_q [$];
  outcome_t    head;
  int unsigned mismatches = 0;
  int unsigned results    = 0;
  int unsigned spill_runs = 0;
  int unsigned fetches    = 0;
  int unsigned no_space   = 0;
  int unsigned refused    = 0;

  assign mismatches_o = mismatches;
  assign results_o    = results;
  assign spill_runs_o = spill_runs;
  assign fetches_o    = fetches;
  assign no_space_o   = no_space;
  assign refused_o    = refused;

  function automatic outcome_t blank_outcome(status_e st);
    outcome_t o;
    o.status  = st;
    o.granted = '0;
    o.fetch   = 1'b0;
    o.spill   = 1'b0;
    o.target  = '0;
    o.word    = '0;
    o.dirty   = changed;
    o.last    = 1'b1;
    return o;
  endfunction

  function automatic void check_field(string name, logic [BlockW-1:0] want,
                                      logic [BlockW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // works out the results of one accepted request and updates the shadow
  task automatic apply_request(logic [1:0] act, logic [BlockW-1:0] val);
    outcome_t    o;
    logic [BlockW-1:0] blk;
    if (act == ACT_FILL) begin
      if (!group_fill) begin
        refused++;
        outcome_q.push_back(blank_outcome(ST_ORDER));
      end else begin
        if (fill_pos == 0) level = (32'(val) > STACK_DEPTH) ? STACK_DEPTH : 32'(val);
        else stack_mem[fill_pos - 1] = val;
        fill_pos++;
        if (fill_pos > STACK_DEPTH) begin
          group_fill = 1'b0;
          fill_pos   = 0;
        end
        outcome_q.push_back(blank_outcome(ST_OK));
      end
    end else if (group_fill || (act != ACT_ALLOC && act != ACT_FREE)) begin
      refused++;
      outcome_q.push_back(blank_outcome(ST_ORDER));
    end else if (act == ACT_ALLOC) begin
      if (level == 0) begin
        no_space++;
        outcome_q.push_back(blank_outcome(ST_NOSPACE));
      end else begin
        level--;
        blk = stack_mem[level];
        if (blk == '0) begin
          // end-of-chain mark popped
          level = 0;
          no_space++;
          outcome_q.push_back(blank_outcome(ST_NOSPACE));
        end else begin
          changed   = 1'b1;
          o         = blank_outcome(ST_OK);
          o.granted = blk;
          if (level == 0) begin
            group_fill = 1'b1;
            fill_pos   = 0;
            o.fetch    = 1'b1;
            fetches++;
          end
          outcome_q.push_back(o);
        end
      end
    end else begin
      changed = 1'b1;
      if (level == 0) begin
        level        = 1;
        stack_mem[0] = '0;
      end
      if (level >= STACK_DEPTH) begin
        o        = blank_outcome(ST_OK);
        o.spill  = 1'b1;
        o.target = val;
        o.word   = BlockW'(level);
        o.last   = 1'b0;
        outcome_q.push_back(o);
        for (int k = 0; k < STACK_DEPTH; k++) begin
          o.word = stack_mem[k];
          o.last = (k == STACK_DEPTH - 1);
          outcome_q.push_back(o);
        end
        stack_mem[0] = val;
        level        = 1;
        spill_runs++;
      end else begin
        stack_mem[level] = val;
        level++;
        outcome_q.push_back(blank_outcome(ST_OK));
      end
    end
  endtask

  // results are compared before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level      = 0;
      group_fill = 1'b0;
      fill_pos   = 0;
      changed    = 1'b0;
      outcome_q.delete();
      outstanding_o <= 0;
      group_due_o   <= 1'b0;
      level_o       <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          $error("result arrived with nothing expected");
        end else begin
          head = outcome_q.pop_front();
          check_field("status", BlockW'(head.status), BlockW'(status_o));
          check_field("granted_block", head.granted, granted_block_o);
          check_field("fetch_request", BlockW'(head.fetch), BlockW'(fetch_request_o));
          check_field("spill_valid", BlockW'(head.spill), BlockW'(spill_valid_o));
          check_field("spill_target", head.target, spill_target_o);
          check_field("spill_word", head.word, spill_word_o);
          check_field("dirty", BlockW'(head.dirty), BlockW'(dirty_o));
          check_field("last", BlockW'(head.last), BlockW'(last_o));
        end
      end
      if (in_valid_i && !in_stall_o) apply_request(action_i, block_number_i);
      outstanding_o <= outcome_q.size();
      group_due_o   <= group_fill;
      level_o       <= level;
    end
  end

endmodule

// ===== tb/sv/grouped_free_block_stack_tb.sv =====
`timescale 1ns / 100ps

module grouped_free_block_stack_tb;
  import gfbs_pkg::*;

  localparam int unsigned Depth          = StackDepthDef;
  // the action code that the block does not define
  localparam logic [1:0]  ACT_SPARE      = 2'd3;
  localparam int unsigned RandomRequests = 480;
  // long receiver hold-off, so that the block backs up and stalls its input
  localparam int unsigned HoldCycles     = 300;
  // an allocate result follows its S_POP state, so a short drain is plenty
  localparam int unsigned DrainCycles    = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [BlockW-1:0] block_number_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        status_o;
  logic [BlockW-1:0] granted_block_o;
  logic              fetch_request_o;
  logic              spill_valid_o;
  logic [BlockW-1:0] spill_target_o;
  logic [BlockW-1:0] spill_word_o;
  logic              dirty_o;
  logic              last_o;

  // figures handed back by the checker
  int unsigned mismatches;
  int unsigned outstanding;
  logic        group_due;
  int unsigned level;
  int unsigned results;
  int unsigned spill_runs;
  int unsigned fetches;
  int unsigned no_space;
  int unsigned refused;

  // stimulus bookkeeping
  bit          calm;       // no idling on either side while set
  int unsigned hold_asks;  // each increment asks the receiver for one hold-off
  int unsigned sent;
  int unsigned useful;

  grouped_free_block_stack #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_block_o(granted_block_o),
    .fetch_request_o(fetch_request_o),
    .spill_valid_o  (spill_valid_o),
    .spill_target_o (spill_target_o),
    .spill_word_o   (spill_word_o),
    .dirty_o        (dirty_o),
    .last_o         (last_o)
  );

  grouped_free_block_stack_checker #(
    .STACK_DEPTH(Depth)
  ) result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_block_o(granted_block_o),
    .fetch_request_o(fetch_request_o),
    .spill_valid_o  (spill_valid_o),
    .spill_target_o (spill_target_o),
    .spill_word_o   (spill_word_o),
    .dirty_o        (dirty_o),
    .last_o         (last_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .group_due_o    (group_due),
    .level_o        (level),
    .results_o      (results),
    .spill_runs_o   (spill_runs),
    .fetches_o      (fetches),
    .no_space_o     (no_space),
    .refused_o      (refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs or results go missing
  initial begin
    #400_000;
    $display("run limit reached, %0d results still outstanding", outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  // block number with a one-in-zero_odds chance of the end-of-chain value,
  // otherwise a mix of all ones, small numbers and the full range
  function automatic logic [BlockW-1:0] pick_block(int unsigned zero_odds);
    int unsigned r;
    r = $urandom_range(0, 19);
    if ($urandom_range(1, zero_odds) == 1) return '0;
    if (r < 2) return '1;
    if (r < 5) return BlockW'($urandom_range(1, 255));
    return BlockW'($urandom_range(1, (1 << BlockW) - 1));
  endfunction

  // count word of a fetched group: mostly in range, sometimes empty, full or oversized
  function automatic logic [BlockW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return BlockW'(Depth);
    if (r == 2) return BlockW'($urandom_range(Depth + 1, (1 << BlockW) - 1));
    if (r == 3) return '1;
    return BlockW'($urandom_range(1, Depth));
  endfunction

  // offers one request, holds it steady until taken, then maybe idles a while
  task automatic send_request(logic [1:0] act, logic [BlockW-1:0] blk);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    block_number_i <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int unsigned served;
    int unsigned left;
    served      = 0;
    left        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0 && served != hold_asks) begin
        served++;
        left = HoldCycles;
      end
      if (left != 0) begin
        left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 14);
      end
    end
  end

  initial begin
    int unsigned burst;
    int unsigned pick;
    bit          fresh_group;
    logic [1:0]  stray;

    // every input at a known value from time zero
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_ALLOC;
    block_number_i = '0;
    calm           = 1'b0;
    hold_asks      = 0;
    sent           = 0;
    useful         = 0;
    fresh_group    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening: empty stack, out-of-order words, end marks, field extremes
    send_request(ACT_ALLOC, '0);              // allocate with nothing free
    send_request(ACT_FILL, '1);               // fill word with no group fetch pending
    send_request(ACT_SPARE, '0);              // undefined action code
    send_request(ACT_FREE, '1);               // free on empty stack plants the end mark
    send_request(ACT_FREE, '0);               // a freed zero behaves as an end mark
    send_request(ACT_FREE, BlockW'(1));
    send_request(ACT_ALLOC, '1);              // grants block 1
    send_request(ACT_ALLOC, '0);              // pops the zero: no space, count cleared
    send_request(ACT_ALLOC, '0);              // empty once more
    send_request(ACT_FREE, BlockW'(24'h800000));
    send_request(ACT_FREE, BlockW'(24'h7FFFFF));
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);
    send_request(ACT_ALLOC, '0);              // reaches the planted end mark
    send_request(ACT_SPARE, '1);

    // random traffic, shaped into free runs, allocate runs and group refills
    while (useful < RandomRequests) begin
      calm <= (useful >= 250 && useful < 330);
      if (hold_asks == 0 && useful >= 120) hold_asks <= 1;
      else if (hold_asks == 1 && useful >= 400) hold_asks <= 2;

      // group_due trails by up to one request, so the scenario just after a
      // group must not read it as a fresh fetch
      if (group_due && !fresh_group) begin
        fresh_group = 1'b1;
        send_request(ACT_FILL, pick_count());
        useful++;
        // now and then the group is cut short and finished by the next one
        burst = ($urandom_range(0, 19) == 0) ? $urandom_range(0, Depth - 1) : Depth;
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 29) == 0)
            send_request(2'($urandom_range(ACT_ALLOC, ACT_SPARE)), pick_block(8));
          send_request(ACT_FILL, pick_block(200));
          useful++;
        end
      end else begin
        fresh_group = 1'b0;
        pick        = $urandom_range(0, 99);
        if (pick < 45) burst = $urandom_range(1, 40);
        else if (pick < 90) burst = $urandom_range(1, level + 2);
        else burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) begin
          // a fetch grant has just gone out: break off and feed the group
          if (k > 0 && group_due) break;
          if (pick >= 90) begin
            send_request(2'($urandom_range(ACT_ALLOC, ACT_SPARE)), pick_block(8));
            useful++;
          end else if ($urandom_range(0, 19) == 0) begin
            stray = ($urandom_range(0, 1) == 0) ? ACT_FILL : ACT_SPARE;
            send_request(stray, pick_block(20));
          end else begin
            send_request((pick < 45) ? ACT_FREE : ACT_ALLOC, pick_block(20));
            useful++;
          end
        end
      end
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    // the checker's outstanding count is registered and trails the requests
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests (%0d shaped), %0d results checked", sent, useful,
             results);
    $display("spill runs %0d, group fetches %0d, no-space replies %0d, refused %0d",
             spill_runs, fetches, no_space, refused);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gfbs_pkg.sv
sv/gfbs_ram.sv
sv/grouped_free_block_stack.sv
tb/sv/grouped_free_block_stack_checker.sv
tb/sv/grouped_free_block_stack_tb.sv
